// File: rtl/cdws_pkg.sv
package cdws_pkg;

  localparam int DENOM_SLOTS = 10;
  localparam int DRINK_SLOTS = 6;
  localparam int NUM_DENOMS_DEF = 10;
  localparam int NUM_DRINKS_DEF = 6;

  localparam int DENOM_IW = 4;
  localparam int STEP_W = 4;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam int MONEY_W = 16;
  localparam int CENT_W = 10;
  localparam int COUNT_W = 8;
  localparam int RECIP_W = 32;
  localparam int RECIP_SH = 31;
  localparam int PROD_W = MONEY_W + RECIP_W;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_SHORT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TAKE,
    ST_SUB,
    ST_FIN,
    ST_RES
  } state_t;

  typedef enum logic {
    REQ_BUY  = 1'b0,
    REQ_LOAD = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                 req_type;
    logic [2:0]           drink_select;
    logic [MONEY_W-1:0]   amount_paid;
    logic [CENT_W-1:0]    preferred_value;
    logic [3:0]           load_index;
    logic [COUNT_W-1:0]   load_count;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   coins_1c;
    logic [COUNT_W-1:0]   coins_2c;
    logic [COUNT_W-1:0]   coins_5c;
    logic [COUNT_W-1:0]   coins_10c;
    logic [COUNT_W-1:0]   coins_20c;
    logic [COUNT_W-1:0]   coins_50c;
    logic [COUNT_W-1:0]   coins_1e;
    logic [COUNT_W-1:0]   coins_2e;
    logic [COUNT_W-1:0]   coins_5e;
    logic [COUNT_W-1:0]   coins_10e;
  } rsp_t;

  typedef struct packed {
    logic in_fire;
    logic is_load;
    logic check_ok;
    logic out_free;
  } seq_sts_t;

  typedef struct packed {
    logic              ready;
    logic              check;
    logic              div;
    logic              take;
    logic              sub;
    logic              fin;
    logic              res;
    logic [STEP_W-1:0] step;
  } seq_ctl_t;

  function automatic logic [CENT_W-1:0] denom_cents(input logic [DENOM_IW-1:0] k);
    logic [CENT_W-1:0] v;
    case (k)
      4'd0:    v = 10'd1;
      4'd1:    v = 10'd2;
      4'd2:    v = 10'd5;
      4'd3:    v = 10'd10;
      4'd4:    v = 10'd20;
      4'd5:    v = 10'd50;
      4'd6:    v = 10'd100;
      4'd7:    v = 10'd200;
      4'd8:    v = 10'd500;
      4'd9:    v = 10'd1000;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  // ceil(2^31 / denomination): exact quotient for any 16-bit amount
  function automatic logic [RECIP_W-1:0] denom_recip(input logic [DENOM_IW-1:0] k);
    logic [RECIP_W-1:0] v;
    case (k)
      4'd0:    v = 32'd2147483648;
      4'd1:    v = 32'd1073741824;
      4'd2:    v = 32'd429496730;
      4'd3:    v = 32'd214748365;
      4'd4:    v = 32'd107374183;
      4'd5:    v = 32'd42949673;
      4'd6:    v = 32'd21474837;
      4'd7:    v = 32'd10737419;
      4'd8:    v = 32'd4294968;
      4'd9:    v = 32'd2147484;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [COUNT_W-1:0] stock_reset(input logic [DENOM_IW-1:0] k);
    logic [COUNT_W-1:0] v;
    case (k)
      4'd0:    v = 8'd50;
      4'd1:    v = 8'd50;
      4'd2:    v = 8'd5;
      4'd3:    v = 8'd50;
      4'd4:    v = 8'd5;
      4'd5:    v = 8'd3;
      4'd6:    v = 8'd3;
      4'd7:    v = 8'd10;
      4'd8:    v = 8'd3;
      4'd9:    v = 8'd1;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [MONEY_W-1:0] price_reset(input logic [2:0] d);
    logic [MONEY_W-1:0] v;
    case (d)
      3'd0:    v = 16'd70;
      3'd1:    v = 16'd80;
      3'd2:    v = 16'd60;
      3'd3:    v = 16'd50;
      3'd4:    v = 16'd50;
      3'd5:    v = 16'd140;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/cdws_mul.sv
module cdws_mul (
  input  logic                          clk,
  input  logic [cdws_pkg::MONEY_W-1:0]  a,
  input  logic [cdws_pkg::RECIP_W-1:0]  b,
  output logic [cdws_pkg::PROD_W-1:0]   prod
);
  import cdws_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// File: rtl/cdws_seq.sv
module cdws_seq #(
  parameter int NUM_DENOMS = cdws_pkg::NUM_DENOMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cdws_pkg::seq_sts_t sts,
  output cdws_pkg::seq_ctl_t ctl
);
  import cdws_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic              last_step;

  assign last_step = (step == STEP_W'(NUM_DENOMS));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sts.in_fire) begin
          state_next = sts.is_load ? ST_RES : ST_CHECK;
        end
      end
      ST_CHECK: state_next = sts.check_ok ? ST_DIV : ST_RES;
      ST_DIV:   state_next = ST_TAKE;
      ST_TAKE:  state_next = ST_SUB;
      ST_SUB:   state_next = last_step ? ST_FIN : ST_DIV;
      ST_FIN:   state_next = ST_RES;
      ST_RES: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.step = step;
    case (state)
      ST_IDLE:  ctl.ready = 1'b1;
      ST_CHECK: ctl.check = 1'b1;
      ST_DIV:   ctl.div = 1'b1;
      ST_TAKE:  ctl.take = 1'b1;
      ST_SUB:   ctl.sub = 1'b1;
      ST_FIN:   ctl.fin = 1'b1;
      ST_RES:   ctl.res = 1'b1;
      default:  ctl.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CHECK) begin
        step <= '0;
      end else if (state == ST_SUB) begin
        step <= step + STEP_W'(1);
      end
    end
  end

endmodule

// File: rtl/change_dispenser_with_stock.sv
// Load word: goes from IDLE straight to RES; the result is registered from RES, then IDLE takes the next word.
// Rejected purchase: IDLE, CHECK, then RES, and back to IDLE for the next word.
// Accepted purchase: CHECK, then DIV, TAKE and SUB for each denomination pass, then FIN and RES;
// the shared multiplier divides in DIV and multiplies back in TAKE, preference pass first.
// One word in flight; a new word is taken while the previous result waits.
// Reset restores prices and coin stock to their defaults and empties the output.
module change_dispenser_with_stock #(
  parameter int NUM_DENOMS = cdws_pkg::NUM_DENOMS_DEF,
  parameter int NUM_DRINKS = cdws_pkg::NUM_DRINKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cdws_pkg::req_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cdws_pkg::rsp_t              out_data,
  input  logic                        cfg_we,
  input  logic [cdws_pkg::CFG_IW-1:0] cfg_index,
  input  logic [cdws_pkg::CFG_DW-1:0] cfg_data
);
  import cdws_pkg::*;

  localparam int AV_IW = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
  localparam int DR_IW = (NUM_DRINKS > 1) ? $clog2(NUM_DRINKS) : 1;

  logic [MONEY_W-1:0]  prices [NUM_DRINKS];
  logic [COUNT_W-1:0]  stock  [NUM_DENOMS];
  logic [COUNT_W-1:0]  avail  [NUM_DENOMS];
  logic [COUNT_W-1:0]  given  [NUM_DENOMS];
  logic [COUNT_W-1:0]  coins  [DENOM_SLOTS];

  req_t                req;
  logic [DENOM_IW-1:0] pidx;
  logic                pref_ok;
  logic [DENOM_IW-1:0] pidx_in;
  logic                pref_ok_in;
  logic [MONEY_W-1:0]  rest;
  status_t             status;

  seq_sts_t            sts;
  seq_ctl_t            ctl;

  logic                in_fire;
  logic                out_free;
  logic                drink_ok;
  logic [MONEY_W-1:0]  price;
  logic                check_ok;
  logic [DENOM_IW-1:0] k;
  logic [COUNT_W-1:0]  avail_k;
  logic [MONEY_W-1:0]  quot;
  logic [COUNT_W-1:0]  n;
  logic [MONEY_W-1:0]  mul_a;
  logic [RECIP_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;
  rsp_t                rsp;

  assign in_ready = ctl.ready;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    pidx_in    = '0;
    pref_ok_in = 1'b0;
    for (int i = 0; i < NUM_DENOMS; i++) begin
      if (denom_cents(DENOM_IW'(i)) == in_data.preferred_value) begin
        pidx_in    = DENOM_IW'(i);
        pref_ok_in = 1'b1;
      end
    end
  end

  assign drink_ok = ({29'd0, req.drink_select} < NUM_DRINKS);
  assign price    = prices[req.drink_select[DR_IW-1:0]];
  assign check_ok = drink_ok && (req.amount_paid >= price) && pref_ok;

  assign sts.in_fire  = in_fire;
  assign sts.is_load  = (in_data.req_type == REQ_LOAD);
  assign sts.check_ok = check_ok;
  assign sts.out_free = out_free;

  cdws_seq #(
    .NUM_DENOMS(NUM_DENOMS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .sts(sts),
    .ctl(ctl)
  );

  // preference pass first, then largest denomination down to the smallest
  assign k = (ctl.step == '0) ? pidx
           : DENOM_IW'(NUM_DENOMS) - DENOM_IW'(ctl.step);
  assign avail_k = avail[k[AV_IW-1:0]];
  assign quot = prod[RECIP_SH +: MONEY_W];
  assign n = (quot > MONEY_W'(avail_k)) ? avail_k : quot[COUNT_W-1:0];

  always_comb begin
    if (ctl.div) begin
      mul_a = rest;
      mul_b = denom_recip(k);
    end else begin
      mul_a = MONEY_W'(n);
      mul_b = RECIP_W'(denom_cents(k));
    end
  end

  cdws_mul u_mul (
    .clk(clk),
    .a(mul_a),
    .b(mul_b),
    .prod(prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DRINKS; i++) begin
        prices[i] <= price_reset(3'(i));
      end
    end else if (cfg_we && ({29'd0, cfg_index} < NUM_DRINKS)) begin
      prices[cfg_index[DR_IW-1:0]] <= cfg_data[MONEY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DENOMS; i++) begin
        stock[i] <= stock_reset(DENOM_IW'(i));
      end
    end else if (in_fire && in_data.req_type == REQ_LOAD) begin
      if ({28'd0, in_data.load_index} < NUM_DENOMS) begin
        stock[in_data.load_index[AV_IW-1:0]] <= in_data.load_count;
      end
    end else if (ctl.fin && rest == '0) begin
      for (int i = 0; i < NUM_DENOMS; i++) begin
        stock[i] <= avail[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req     <= in_data;
      pidx    <= pidx_in;
      pref_ok <= pref_ok_in;
      status  <= STAT_OK;
      for (int i = 0; i < NUM_DENOMS; i++) begin
        given[i] <= '0;
      end
    end
    if (ctl.check) begin
      rest <= req.amount_paid - price;
      if (!check_ok) begin
        status <= STAT_REJECT;
      end
      for (int i = 0; i < NUM_DENOMS; i++) begin
        avail[i] <= stock[i];
      end
    end
    if (ctl.take) begin
      avail[k[AV_IW-1:0]] <= avail_k - n;
      given[k[AV_IW-1:0]] <= given[k[AV_IW-1:0]] + n;
    end
    if (ctl.sub) begin
      rest <= rest - prod[MONEY_W-1:0];
    end
    if (ctl.fin) begin
      status <= (rest == '0) ? STAT_OK : STAT_SHORT;
    end
  end

  always_comb begin
    for (int i = 0; i < DENOM_SLOTS; i++) begin
      coins[i] = '0;
    end
    for (int i = 0; i < NUM_DENOMS; i++) begin
      coins[i] = (status == STAT_OK) ? given[i] : '0;
    end
    rsp.status    = status;
    rsp.coins_1c  = coins[0];
    rsp.coins_2c  = coins[1];
    rsp.coins_5c  = coins[2];
    rsp.coins_10c = coins[3];
    rsp.coins_20c = coins[4];
    rsp.coins_50c = coins[5];
    rsp.coins_1e  = coins[6];
    rsp.coins_2e  = coins[7];
    rsp.coins_5e  = coins[8];
    rsp.coins_10e = coins[9];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res && out_free) begin
      out_data <= rsp;
    end
  end

endmodule
